// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the deframer.
// Standalone header; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tvd_pkg.sv =====
// Package for the TLV deframer with variable-length length field.
// Holds phase, role and error codes, defaults and the result word type.
// No dependencies.
package tvd_pkg;

	localparam int DEF_LENGTH_WIDTH     = 32;
	localparam int DEF_MAX_LENGTH_BYTES = 5;

	localparam int PAYLOAD_LENGTH_W = 32;

	localparam logic [1:0] PH_CMD  = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_PAY  = 2'd2;
	localparam logic [1:0] PH_SKIP = 2'd3;

	localparam logic [1:0] ROLE_COMMAND = 2'd0;
	localparam logic [1:0] ROLE_LENGTH  = 2'd1;
	localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
	localparam logic [1:0] ROLE_SKIP    = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_LEN_TRUNC = 2'd1;
	localparam logic [1:0] ERR_PAY_TRUNC = 2'd2;
	localparam logic [1:0] ERR_LEN_LONG  = 2'd3;

	typedef struct packed {
		logic [1:0]                  role;
		logic [7:0]                  command;
		logic [PAYLOAD_LENGTH_W-1:0] payload_length;
		logic [7:0]                  payload_byte;
		logic                        packet_done;
		logic [1:0]                  error_code;
	} result_t;

endpackage

// ===== sv/tvd_core.sv =====
// Per-byte parser state and result logic of the deframer.
// Depends on tvd_pkg; state advances only when the top level moves a word on.
module tvd_core import tvd_pkg::*; #(
	parameter int LENGTH_WIDTH     = DEF_LENGTH_WIDTH,
	parameter int MAX_LENGTH_BYTES = DEF_MAX_LENGTH_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] data_byte,
	input  logic       buffer_last,
	output result_t    result
);

	localparam int CW = $clog2(MAX_LENGTH_BYTES + 1);
	localparam logic [CW-1:0] LAST_GROUP = CW'(MAX_LENGTH_BYTES - 1);

	logic [1:0]              phase_q, phase_d;
	logic [7:0]              command_q, command_d;
	logic [LENGTH_WIDTH-1:0] acc_q, acc_d;
	logic [LENGTH_WIDTH-1:0] remaining_q, remaining_d;
	logic [CW-1:0]           groups_q, groups_d;

	logic [LENGTH_WIDTH-1:0] acc_shift;
	logic [LENGTH_WIDTH-1:0] rem_dec;
	logic [1:0]              role;
	logic [7:0]              pbyte;
	logic                    done;
	logic [1:0]              err;
	logic [PAYLOAD_LENGTH_W-1:0] len_out;

	assign acc_shift = {acc_q[LENGTH_WIDTH-8:0], data_byte[6:0]};
	assign rem_dec   = remaining_q - LENGTH_WIDTH'(1);

	always_comb begin
		phase_d     = phase_q;
		command_d   = command_q;
		acc_d       = acc_q;
		remaining_d = remaining_q;
		groups_d    = groups_q;
		role        = ROLE_SKIP;
		pbyte       = 8'd0;
		done        = 1'b0;
		err         = ERR_NONE;
		unique case (phase_q)
			PH_CMD: begin
				role        = ROLE_COMMAND;
				command_d   = data_byte;
				acc_d       = '0;
				remaining_d = '0;
				groups_d    = '0;
				if (buffer_last) begin
					err = ERR_LEN_TRUNC;
				end else begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				role     = ROLE_LENGTH;
				groups_d = groups_q + CW'(1);
				acc_d    = acc_shift;
				if (data_byte[7]) begin
					if (groups_q >= LAST_GROUP) begin
						err = ERR_LEN_LONG;
					end else if (buffer_last) begin
						err = ERR_LEN_TRUNC;
					end
				end else begin
					remaining_d = acc_shift;
					if (acc_shift == '0) begin
						done    = 1'b1;
						phase_d = PH_CMD;
					end else if (buffer_last) begin
						err = ERR_PAY_TRUNC;
					end else begin
						phase_d = PH_PAY;
					end
				end
			end
			PH_PAY: begin
				role        = ROLE_PAYLOAD;
				pbyte       = data_byte;
				remaining_d = rem_dec;
				if (rem_dec == '0) begin
					done    = 1'b1;
					phase_d = PH_CMD;
				end else if (buffer_last) begin
					err = ERR_PAY_TRUNC;
				end
			end
			PH_SKIP: begin
				role = ROLE_SKIP;
			end
		endcase
		if (err != ERR_NONE) begin
			phase_d = PH_SKIP;
		end
		if (buffer_last) begin
			phase_d = PH_CMD;
		end
	end

	for (genvar i = 0; i < PAYLOAD_LENGTH_W; i++) begin : g_len
		if (i < LENGTH_WIDTH) begin : g_bit
			assign len_out[i] = acc_d[i];
		end else begin : g_zero
			assign len_out[i] = 1'b0;
		end
	end

	assign result = '{
		role:           role,
		command:        command_d,
		payload_length: len_out,
		payload_byte:   pbyte,
		packet_done:    done,
		error_code:     err
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CMD;
			command_q   <= '0;
			acc_q       <= '0;
			remaining_q <= '0;
			groups_q    <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			command_q   <= command_d;
			acc_q       <= acc_d;
			remaining_q <= remaining_d;
			groups_q    <= groups_d;
		end
	end

endmodule

// ===== sv/tlv_vlq_deframer_top.sv =====
// Top level of the TLV deframer with variable-length length field.
// Depends on tvd_pkg, tvd_core and assert_macros.svh.
//
// The input channel takes one word per accepted transfer: a buffer byte and
// a flag that marks the last byte of the buffer. The output channel gives
// exactly one result word per input word, in order: the role of the byte,
// the packet command, the decoded length, the payload byte, a packet
// completion flag and an error code.
// A word accepted sits in the input register and is then parsed into the
// result register, which drives the output. One word is accepted every
// cycle while the receiver does not stall the output.
// Reset empties both registers and returns the parser to expecting a command
// byte. While the receiver stalls, the result register holds; the input
// register still takes one further word, after which the input is stalled.
module tlv_vlq_deframer_top import tvd_pkg::*; #(
	parameter int LENGTH_WIDTH     = DEF_LENGTH_WIDTH,
	parameter int MAX_LENGTH_BYTES = DEF_MAX_LENGTH_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        buffer_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  role,
	output logic [7:0]  command,
	output logic [31:0] payload_length,
	output logic [7:0]  payload_byte,
	output logic        packet_done,
	output logic [1:0]  error_code
);

	`include "assert_macros.svh"

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    result;
	logic       blocked_s2;
	logic       advance;

	assign blocked_s2 = valid_s2 && out_stall;
	assign advance    = valid_s1 && !blocked_s2;
	assign in_stall   = valid_s1 && blocked_s2;

	tvd_core #(
		.LENGTH_WIDTH     (LENGTH_WIDTH),
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.data_byte   (byte_s1),
		.buffer_last (last_s1),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (!blocked_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= buffer_last;
		end
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign out_valid      = valid_s2;
	assign role           = res_s2.role;
	assign command        = res_s2.command;
	assign payload_length = res_s2.payload_length;
	assign payload_byte   = res_s2.payload_byte;
	assign packet_done    = res_s2.packet_done;
	assign error_code     = res_s2.error_code;

	`ASSERT_IMPLY(a_skip_quiet, clk, arst_n, out_valid && role == ROLE_SKIP,
		error_code == ERR_NONE && !packet_done && payload_byte == 8'd0,
		"skipped word carries data")
	`ASSERT_IMPLY(a_done_clean, clk, arst_n, out_valid && packet_done,
		error_code == ERR_NONE, "packet completed with an error")
	`ASSERT_IMPLY(a_long_on_len, clk, arst_n, out_valid && error_code == ERR_LEN_LONG,
		role == ROLE_LENGTH, "length overrun flagged outside the length field")
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, valid_s1 && blocked_s2,
		valid_s1 && $stable(byte_s1) && $stable(last_s1),
		"input register lost a word while stalled")

endmodule
